[sv/xsfb_pkg.sv]
// ----------------------------------------------------------------------------
// xsfb_pkg - shared definitions for the XOR sprite framebuffer
// Screen geometry, command codes, modulo tables and controller/datapath
// command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package xsfb_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int LINE_W        = $clog2(SCREEN_HEIGHT);

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Modulo lookup tables for 8-bit coordinates
    typedef logic [COL_W-1:0]  col_tab_t  [256];
    typedef logic [LINE_W-1:0] line_tab_t [256];

    function automatic col_tab_t build_col_tab();
        col_tab_t t;
        int       c;
        c = 0;
        for (int i = 0; i < 256; i++) begin
            t[i] = COL_W'(c);
            c = c + 1;
            if (c == SCREEN_WIDTH) c = 0;
        end
        return t;
    endfunction

    function automatic line_tab_t build_line_tab();
        line_tab_t t;
        int        c;
        c = 0;
        for (int i = 0; i < 256; i++) begin
            t[i] = LINE_W'(c);
            c = c + 1;
            if (c == SCREEN_HEIGHT) c = 0;
        end
        return t;
    endfunction

    localparam col_tab_t  COL_MOD_TAB  = build_col_tab();
    localparam line_tab_t LINE_MOD_TAB = build_line_tab();

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // item accepted: latch fields, read line
        logic exec;   // modify, write back, load result
    } xsfb_ctrl_t;

endpackage

`default_nettype wire

[sv/xsfb_ctrl.sv]
// ----------------------------------------------------------------------------
// xsfb_ctrl - controller for the XOR sprite framebuffer
// Two-state sequencer (accept, execute) and result valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module xsfb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output xsfb_pkg::xsfb_ctrl_t   ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // Take an item only when idle and the result slot is empty or frees up this cycle
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign ctrl.load = s_tvalid && s_tready;
    assign ctrl.exec = (state_reg == ST_EXEC);
    assign m_tvalid  = m_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctrl.load) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (ctrl.exec) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[sv/xsfb_datapath.sv]
// ----------------------------------------------------------------------------
// xsfb_datapath - line memory and XOR/read logic
// One memory word per screen line, a valid bit per line for fast clear,
// sprite mask rotation, collision detect and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module xsfb_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire xsfb_pkg::xsfb_ctrl_t ctrl,
    input  wire logic [1:0]        cmd,
    input  wire logic [7:0]        x_pos,
    input  wire logic [7:0]        y_pos,
    input  wire logic [3:0]        row_offset,
    input  wire logic [7:0]        row_bits,
    input  wire logic              last_row,
    output logic                   collision,
    output logic [7:0]             read_bits,
    output logic                   sprite_done
);

    localparam int W  = xsfb_pkg::SCREEN_WIDTH;
    localparam int H  = xsfb_pkg::SCREEN_HEIGHT;
    localparam int CW = xsfb_pkg::COL_W;
    localparam int LW = xsfb_pkg::LINE_W;

    // Line memory and per-line valid bits
    logic [W-1:0]  frame_mem [H];
    logic [H-1:0]  row_valid_reg;

    // Latched item
    logic [1:0]    cmd_reg;
    logic [CW-1:0] col_reg;
    logic [LW-1:0] line_reg;
    logic          rowz_reg;
    logic [7:0]    bits_reg;
    logic          last_reg;
    logic [W-1:0]  rdata_reg;
    logic          rvalid_reg;
    logic          coll_acc_reg, coll_acc_next;

    // Result registers
    logic          collision_reg;
    logic [7:0]    read_bits_reg;
    logic          sprite_done_reg;

    // Address generation: wrapped line for draw, y line for read
    logic [LW-1:0] y_mod, r_mod, draw_line, addr;
    logic [LW:0]   line_sum;

    always_comb begin
        y_mod     = xsfb_pkg::LINE_MOD_TAB[y_pos];
        r_mod     = xsfb_pkg::LINE_MOD_TAB[{4'b0000, row_offset}];
        line_sum  = {1'b0, y_mod} + {1'b0, r_mod};
        if (line_sum >= (LW+1)'(H)) begin
            line_sum = line_sum - (LW+1)'(H);
        end
        draw_line = line_sum[LW-1:0];
        addr      = (cmd == xsfb_pkg::CMD_DRAW) ? draw_line : y_mod;
    end

    // Sprite mask, collision and read extraction
    logic [W-1:0]  line_word, mask, new_line;
    logic [7:0]    rev_bits, ext_bits, rd_bits;
    logic [W+7:0]  wide, ext;
    logic          hit;

    always_comb begin
        line_word = rvalid_reg ? rdata_reg : '0;
        for (int k = 0; k < 8; k++) begin
            rev_bits[k] = bits_reg[7-k];
        end
        wide     = {{W{1'b0}}, rev_bits} << col_reg;
        mask     = wide[W-1:0] | W'(wide[W+7:W]);
        hit      = |(mask & line_word);
        new_line = line_word ^ mask;
        ext      = {line_word[7:0], line_word} >> col_reg;
        ext_bits = ext[7:0];
        for (int k = 0; k < 8; k++) begin
            rd_bits[7-k] = ext_bits[k];
        end
    end

    // Running collision flag
    always_comb begin
        coll_acc_next = coll_acc_reg;
        if (cmd_reg == xsfb_pkg::CMD_DRAW) begin
            coll_acc_next = (rowz_reg ? 1'b0 : coll_acc_reg) | hit;
        end
    end

    // Item latch and memory read
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg    <= cmd;
            col_reg    <= xsfb_pkg::COL_MOD_TAB[x_pos];
            line_reg   <= addr;
            rowz_reg   <= (row_offset == 4'd0);
            bits_reg   <= row_bits;
            last_reg   <= last_row;
            rdata_reg  <= frame_mem[addr];
            rvalid_reg <= row_valid_reg[addr];
        end
    end

    // Memory write-back
    always_ff @(posedge aclk) begin
        if (ctrl.exec && cmd_reg == xsfb_pkg::CMD_DRAW) begin
            frame_mem[line_reg] <= new_line;
        end
    end

    // Valid bits and collision flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            coll_acc_reg  <= 1'b0;
        end else if (ctrl.exec) begin
            coll_acc_reg <= coll_acc_next;
            if (cmd_reg == xsfb_pkg::CMD_CLEAR) begin
                row_valid_reg <= '0;
            end else if (cmd_reg == xsfb_pkg::CMD_DRAW) begin
                row_valid_reg[line_reg] <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            collision_reg   <= coll_acc_next;
            read_bits_reg   <= (cmd_reg == xsfb_pkg::CMD_READ) ? rd_bits : 8'h00;
            sprite_done_reg <= (cmd_reg == xsfb_pkg::CMD_DRAW) ? last_reg : 1'b0;
        end
    end

    assign collision   = collision_reg;
    assign read_bits   = read_bits_reg;
    assign sprite_done = sprite_done_reg;

endmodule

`default_nettype wire

[sv/xor_sprite_framebuffer_core.sv]
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_core - one-bit XOR sprite framebuffer
// Clear, draw one sprite row with collision detect, or read eight pixels.
//
//   Channel  Dir  Payload                                   Handshake
//   s_*      in   tuser cmd; tlast last_row; tdata fields    tvalid/tready
//   m_*      out  tlast sprite_done; tdata collision, bits   tvalid/tready
//
// Each item is accepted with its line read, then modified and written back
// through the single line-memory port before the next is taken. Clear takes
// the same path (per-line valid bits are dropped at once).
// Reset leaves the screen cleared and the collision flag low; no clear pass.
// A stalled result holds in the output register; the next item is taken in
// the cycle that result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_sprite_framebuffer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] x_pos, [15:8] y_pos, [19:16] row_offset, [27:20] row_bits
    input  wire logic [xsfb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,
    // [1:0] cmd
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] collision, [8:1] read_bits
    output logic [xsfb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);

    xsfb_pkg::xsfb_ctrl_t ctrl;
    logic                 collision;
    logic [7:0]           read_bits;

    xsfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    xsfb_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cmd         (s_tuser),
        .x_pos       (s_tdata[7:0]),
        .y_pos       (s_tdata[15:8]),
        .row_offset  (s_tdata[19:16]),
        .row_bits    (s_tdata[27:20]),
        .last_row    (s_tlast),
        .collision   (collision),
        .read_bits   (read_bits),
        .sprite_done (m_tlast)
    );

    // Pack result
    assign m_tdata = {(xsfb_pkg::M_TDATA_W-9)'(0), read_bits, collision};

endmodule

`default_nettype wire

[sv/xsfb_checker.sv]
// ----------------------------------------------------------------------------
// xsfb_checker - port-level checks for the XOR sprite framebuffer
// Result hold under stall, item spacing, result latency, draw/read payload.
// ----------------------------------------------------------------------------
`default_nettype none

module xsfb_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [xsfb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [xsfb_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One item in flight: no accept right after an accept
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");

    // Result valid follows an accept through the execute state and the valid register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing after accept");

    // A finished sprite is a draw, which returns no read pixels
    a_done_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[8:1] == 8'h00)
        else $error("sprite_done with read pixels");

endmodule

bind xor_sprite_framebuffer_core xsfb_checker u_chk (.*);

`default_nettype wire

[dv/xor_sprite_framebuffer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_core_test - self-checking bench for the XOR sprite
// framebuffer core
// Drives clear, draw-row, read and the unused command through the input
// stream and predicts the collision flag, read pixels and sprite-done flag
// of each item from a private copy of the screen. The predicted items are
// compared in order with the result stream. Both sides idle at random, and
// the result side stalls once for a long stretch so the core backs up.
// ----------------------------------------------------------------------------

module xor_sprite_framebuffer_core_test;

    // Unused command code, decoded as no operation
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 3000;
    localparam int STALL_AFTER  = 400;
    localparam int STALL_CYCLES = 300;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_offset;
        logic [7:0] row_bits;
        logic       last_row;
    } fb_item_t;

    typedef struct {
        logic       collision;
        logic [7:0] read_bits;
        logic       sprite_done;
    } fb_result_t;

    // Screen copy, collision flag and the queue of results still owed
    class framebuffer_scoreboard;
        bit         screen [xsfb_pkg::SCREEN_HEIGHT][xsfb_pkg::SCREEN_WIDTH];
        bit         hit_flag;
        fb_result_t owed_results [$];
        int         error_count;
        int         result_count;

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted item to the screen copy and queue its result
        function void note_item(fb_item_t it);
            fb_result_t r;
            int         line;
            int         col;
            r.read_bits   = 8'h00;
            r.sprite_done = 1'b0;
            case (it.cmd)
                xsfb_pkg::CMD_CLEAR: begin
                    foreach (screen[l, c]) screen[l][c] = 1'b0;
                end
                xsfb_pkg::CMD_DRAW: begin
                    if (it.row_offset == 4'd0) hit_flag = 1'b0;
                    line = (int'(it.y_pos) + int'(it.row_offset))
                           % xsfb_pkg::SCREEN_HEIGHT;
                    for (int k = 0; k < 8; k++) begin
                        col = (int'(it.x_pos) + k) % xsfb_pkg::SCREEN_WIDTH;
                        if (it.row_bits[7-k]) begin
                            if (screen[line][col]) hit_flag = 1'b1;
                            screen[line][col] = ~screen[line][col];
                        end
                    end
                    r.sprite_done = it.last_row;
                end
                xsfb_pkg::CMD_READ: begin
                    line = int'(it.y_pos) % xsfb_pkg::SCREEN_HEIGHT;
                    for (int k = 0; k < 8; k++) begin
                        col = (int'(it.x_pos) + k) % xsfb_pkg::SCREEN_WIDTH;
                        r.read_bits[7-k] = screen[line][col];
                    end
                end
                default: ;
            endcase
            r.collision = hit_flag;
            owed_results.push_back(r);
        endfunction

        // Compare one result item with the oldest owed result
        task check_result(logic collision, logic [7:0] read_bits, logic sprite_done);
            fb_result_t e;
            if (owed_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed", result_count));
                result_count++;
                return;
            end
            e = owed_results.pop_front();
            if (collision !== e.collision)
                report($sformatf("result %0d collision %b, want %b",
                                 result_count, collision, e.collision));
            if (read_bits !== e.read_bits)
                report($sformatf("result %0d read_bits %h, want %h",
                                 result_count, read_bits, e.read_bits));
            if (sprite_done !== e.sprite_done)
                report($sformatf("result %0d sprite_done %b, want %b",
                                 result_count, sprite_done, e.sprite_done));
            result_count++;
        endtask
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [xsfb_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic [1:0]                      s_tuser  = 2'd0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [xsfb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    framebuffer_scoreboard sb = new;
    int items_sent = 0;
    int send_calm  = 0;
    int recv_calm  = 0;

    always #5 aclk = ~aclk;

    xor_sprite_framebuffer_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Random idle gap before an item, with occasional runs of none
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 4);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                             logic [3:0] row, logic [7:0] bits, logic last);
        fb_item_t it;
        int       gap;
        it  = '{cmd, x, y, row, bits, last};
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, bits, row, y, x};
        s_tuser  <= cmd;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Result side: random ready gaps, one long stall once the core is busy
    task automatic collect_results();
        int gap;
        forever begin
            gap = draw_gap(recv_calm);
            if (sb.result_count == STALL_AFTER) gap = STALL_CYCLES;
            if (gap > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata[0], m_tdata[8:1], m_tlast);
        end
    endtask

    // One well-formed sprite of 1..15 rows, sometimes read back
    task automatic draw_sprite();
        logic [7:0] x;
        logic [7:0] y;
        int         rows;
        x    = ($urandom_range(0, 3) == 0) ? 8'(56 + $urandom_range(0, 7)) : 8'($urandom);
        y    = ($urandom_range(0, 3) == 0) ? 8'(24 + $urandom_range(0, 7)) : 8'($urandom);
        rows = $urandom_range(1, 15);
        for (int r = 0; r < rows; r++)
            send_item(xsfb_pkg::CMD_DRAW, x, y, 4'(r),
                      ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom), r == rows - 1);
        if ($urandom_range(0, 2) == 0)
            for (int r = 0; r < rows; r++)
                send_item(xsfb_pkg::CMD_READ, x, 8'(y + r), 4'($urandom), 8'($urandom),
                          1'($urandom));
    endtask

    // Cycles without any accepted item end the run
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int pick;
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        fork
            collect_results();
        join_none

        // Directed: reset state, screen edges, collision, clear, unused command
        send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd0,  8'hFF, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd1,  8'h81, 1'b1);
        send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd1,   4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd60,  8'd31,  4'd0,  8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_READ,  8'd60,  8'd31,  4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd0,  8'hF0, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd15, 8'h00, 1'b1);
        send_item(xsfb_pkg::CMD_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd0,   4'd9,  8'hFF, 1'b1);
        send_item(CMD_NOP,             8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_DRAW,  8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_READ,  8'd255, 8'd14,  4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'd255, 8'd255, 4'd0,  8'h01, 1'b0);
        send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd31,  4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_READ,  8'd255, 8'd255, 4'd0,  8'h00, 1'b0);
        send_item(xsfb_pkg::CMD_DRAW,  8'h80,  8'h80,  4'd0,  8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_DRAW,  8'h80,  8'h80,  4'd0,  8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_READ,  8'd200, 8'd100, 4'd5,  8'hAA, 1'b1);
        send_item(xsfb_pkg::CMD_CLEAR, 8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1);
        send_item(xsfb_pkg::CMD_READ,  8'h80,  8'h80,  4'd0,  8'h00, 1'b0);

        // Random: mostly whole sprites, plus reads, stray rows, unused commands and clears
        while (items_sent < 22 + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                draw_sprite();
            else if (pick < 82)
                send_item(xsfb_pkg::CMD_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            else if (pick < 94)
                send_item(xsfb_pkg::CMD_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            else if (pick < 97)
                send_item(CMD_NOP, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
            else
                send_item(xsfb_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom));
        end
        @(negedge aclk) s_tvalid <= 1'b0;

        // Drain, then wait for anything stray
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) sb.report("results still owed at end of run");

        if (sb.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
